// ===== sv/ncc_pkg.sv =====
package ncc_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int MAX_PAIRS  = 65536;
    localparam int CNT_BITS   = 17;
    localparam int SUM_BITS   = 24;
    localparam int SQ_BITS    = 32;
    localparam int OPW        = 49;
    localparam int PRODW      = 2 * OPW;
    localparam int QUOTW      = 31;
    localparam int REMW       = PRODW + QUOTW - 1;
    localparam int ROOTW      = 16;
    localparam int CORRW      = 16;
    localparam int CORR_MAX   = 32767;
    localparam int MUL_STEPS  = OPW;
    localparam int DIV_STEPS  = QUOTW;
    localparam int SQRT_STEPS = ROOTW;
    localparam int STEP_W     = $clog2(MUL_STEPS);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_MUL_STORE,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_SQRT_LOAD,
        ST_SQRT_RUN,
        ST_DONE
    } ncc_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_STORE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_FINISH
    } ncc_op_t;

    // Product slots, in the order the controller works through them.
    typedef enum logic [2:0] {
        SEL_NAA,
        SEL_SA2,
        SEL_NBB,
        SEL_SB2,
        SEL_NAB,
        SEL_SAB,
        SEL_VAR,
        SEL_COV
    } ncc_sel_t;

    typedef struct packed {
        logic     accumulate;
        ncc_op_t  op;
        ncc_sel_t sel;
    } ncc_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic out_valid;
    } ncc_status_t;

endpackage

// ===== sv/ncc_ctrl.sv =====
module ncc_ctrl import ncc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  ncc_status_t status,
    output ncc_cmd_t    cmd
);

    ncc_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    ncc_sel_t           sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            cnt_reg   <= '0;
            sel_reg   <= SEL_NAA;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        s_tready       = 1'b0;
        cmd.accumulate = 1'b0;
        cmd.op         = OP_IDLE;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_ACCUM: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accumulate = 1'b1;
                    if (s_tlast) begin
                        sel_next   = SEL_NAA;
                        state_next = ST_MUL_LOAD;
                    end
                end
            end
            ST_MUL_LOAD: begin
                cmd.op     = OP_MUL_LOAD;
                cnt_next   = '0;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1)) begin
                    state_next = ST_MUL_STORE;
                end
            end
            ST_MUL_STORE: begin
                cmd.op = OP_MUL_STORE;
                case (sel_reg)
                    SEL_SAB: state_next = ST_CHECK;
                    SEL_COV: state_next = ST_DIV_LOAD;
                    default: begin
                        sel_next   = ncc_sel_t'(sel_reg + 3'd1);
                        state_next = ST_MUL_LOAD;
                    end
                endcase
            end
            ST_CHECK: begin
                if (status.degenerate) begin
                    state_next = ST_DONE;
                end else begin
                    sel_next   = SEL_VAR;
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                cmd.op     = OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQRT_LOAD;
                end
            end
            ST_SQRT_LOAD: begin
                cmd.op     = OP_SQRT_LOAD;
                cnt_next   = '0;
                state_next = ST_SQRT_RUN;
            end
            ST_SQRT_RUN: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_valid) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// ===== sv/ncc_datapath.sv =====
module ncc_datapath import ncc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncc_cmd_t              cmd,
    output ncc_status_t           status,
    input  logic [PIXEL_BITS-1:0] pixel_a,
    input  logic [PIXEL_BITS-1:0] pixel_b,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [CORRW-1:0]      correlation,
    output logic                  degenerate
);

    // Running sums.
    logic [SUM_BITS-1:0]     sum_a_reg, sum_b_reg;
    logic [SQ_BITS-1:0]      sum_aa_reg, sum_bb_reg, sum_ab_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic [2*PIXEL_BITS-1:0] sq_a, sq_b, prod_ab;

    assign sq_a    = (2*PIXEL_BITS)'(pixel_a) * (2*PIXEL_BITS)'(pixel_a);
    assign sq_b    = (2*PIXEL_BITS)'(pixel_b) * (2*PIXEL_BITS)'(pixel_b);
    assign prod_ab = (2*PIXEL_BITS)'(pixel_a) * (2*PIXEL_BITS)'(pixel_b);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_FINISH) begin
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            sum_aa_reg <= '0;
            sum_bb_reg <= '0;
            sum_ab_reg <= '0;
            count_reg  <= '0;
        end else if (cmd.accumulate && count_reg < CNT_BITS'(MAX_PAIRS)) begin
            sum_a_reg  <= sum_a_reg + SUM_BITS'(pixel_a);
            sum_b_reg  <= sum_b_reg + SUM_BITS'(pixel_b);
            sum_aa_reg <= sum_aa_reg + SQ_BITS'(sq_a);
            sum_bb_reg <= sum_bb_reg + SQ_BITS'(sq_b);
            sum_ab_reg <= sum_ab_reg + SQ_BITS'(prod_ab);
            count_reg  <= count_reg + 1'b1;
        end
    end

    // Stored products and the variance and covariance terms built from them.
    logic [OPW-1:0]     naa_reg, sa2_reg, nbb_reg, sb2_reg, nab_reg, sab_reg;
    logic [PRODW-1:0]   pv_reg, c2_reg;
    logic signed [OPW:0] va, vb, cov;
    logic [OPW:0]       cov_abs;
    logic               cov_neg, degen;

    assign va      = $signed({1'b0, naa_reg}) - $signed({1'b0, sa2_reg});
    assign vb      = $signed({1'b0, nbb_reg}) - $signed({1'b0, sb2_reg});
    assign cov     = $signed({1'b0, nab_reg}) - $signed({1'b0, sab_reg});
    assign cov_neg = cov[OPW];
    assign cov_abs = cov_neg ? (~cov + 1'b1) : cov;
    assign degen   = va[OPW] || (va == '0) || vb[OPW] || (vb == '0);

    // Shift-and-add multiplier, one multiplier bit a cycle.
    logic [OPW-1:0]   mul_x, mul_y, mplier_reg;
    logic [PRODW-1:0] mcand_reg, acc_reg;

    always_comb begin
        case (cmd.sel)
            SEL_NAA: begin mul_x = OPW'(count_reg); mul_y = OPW'(sum_aa_reg); end
            SEL_SA2: begin mul_x = OPW'(sum_a_reg); mul_y = OPW'(sum_a_reg); end
            SEL_NBB: begin mul_x = OPW'(count_reg); mul_y = OPW'(sum_bb_reg); end
            SEL_SB2: begin mul_x = OPW'(sum_b_reg); mul_y = OPW'(sum_b_reg); end
            SEL_NAB: begin mul_x = OPW'(count_reg); mul_y = OPW'(sum_ab_reg); end
            SEL_SAB: begin mul_x = OPW'(sum_a_reg); mul_y = OPW'(sum_b_reg); end
            SEL_VAR: begin mul_x = va[OPW-1:0];     mul_y = vb[OPW-1:0];     end
            SEL_COV: begin mul_x = cov_abs[OPW-1:0]; mul_y = cov_abs[OPW-1:0]; end
            default: begin mul_x = '0;              mul_y = '0;              end
        endcase
    end

    // Restoring divider and digit-by-digit square root.
    logic [REMW-1:0]    rem_reg, dv_reg;
    logic [QUOTW-1:0]   quot_reg;
    logic               rem_ge;
    logic [ROOTW-1:0]   root_reg, mask_reg, trial;
    logic [2*ROOTW-1:0] trial_sq;

    assign rem_ge   = rem_reg >= dv_reg;
    assign trial    = root_reg | mask_reg;
    assign trial_sq = (2*ROOTW)'(trial) * (2*ROOTW)'(trial);

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_MUL_LOAD: begin
                acc_reg    <= '0;
                mcand_reg  <= {{(PRODW-OPW){1'b0}}, mul_x};
                mplier_reg <= mul_y;
            end
            OP_MUL_STEP: begin
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            OP_MUL_STORE: begin
                case (cmd.sel)
                    SEL_NAA: naa_reg <= acc_reg[OPW-1:0];
                    SEL_SA2: sa2_reg <= acc_reg[OPW-1:0];
                    SEL_NBB: nbb_reg <= acc_reg[OPW-1:0];
                    SEL_SB2: sb2_reg <= acc_reg[OPW-1:0];
                    SEL_NAB: nab_reg <= acc_reg[OPW-1:0];
                    SEL_SAB: sab_reg <= acc_reg[OPW-1:0];
                    SEL_VAR: pv_reg  <= acc_reg;
                    SEL_COV: c2_reg  <= acc_reg;
                    default: pv_reg  <= acc_reg;
                endcase
            end
            OP_DIV_LOAD: begin
                rem_reg  <= {c2_reg, {(REMW-PRODW){1'b0}}};
                dv_reg   <= {pv_reg, {(REMW-PRODW){1'b0}}};
                quot_reg <= '0;
            end
            OP_DIV_STEP: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - dv_reg;
                end
                quot_reg <= {quot_reg[QUOTW-2:0], rem_ge};
                dv_reg   <= dv_reg >> 1;
            end
            OP_SQRT_LOAD: begin
                root_reg <= '0;
                mask_reg <= {1'b1, {(ROOTW-1){1'b0}}};
            end
            OP_SQRT_STEP: begin
                if (trial_sq <= (2*ROOTW)'(quot_reg)) begin
                    root_reg <= trial;
                end
                mask_reg <= mask_reg >> 1;
            end
            default: begin
            end
        endcase
    end

    // Result register.
    logic                out_valid_reg;
    logic [CORRW-1:0]    corr_reg, corr_next;
    logic                degen_reg;
    logic [CORRW-2:0]    mag;

    assign mag = (root_reg > ROOTW'(CORR_MAX)) ? (CORRW-1)'(CORR_MAX) : root_reg[CORRW-2:0];

    always_comb begin
        if (degen) begin
            corr_next = '0;
        end else if (cov_neg) begin
            corr_next = CORRW'(0) - {1'b0, mag};
        end else begin
            corr_next = {1'b0, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_FINISH) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            corr_reg  <= corr_next;
            degen_reg <= degen;
        end
    end

    assign status.degenerate = degen;
    assign status.out_valid  = out_valid_reg;
    assign m_tvalid          = out_valid_reg;
    assign correlation       = corr_reg;
    assign degenerate        = degen_reg;

endmodule

// ===== sv/normalized_cross_correlation_core.sv =====
// Channel   Direction  Ports                       Contents
// s_        in         tvalid tready tdata tlast   one pixel pair a word, tlast ends a window
// m_        out        tvalid tready tdata tuser   one correlation word per window
//
// Pixel pairs are taken one word per cycle while the block is gathering sums.
// After the word marked tlast the block is busy with eight shift-and-add
// products, a restoring division and a square root, all on one shared
// datapath; when a variance term is not positive it stops after six products.
// A held result stalls the next result's hand-over, and gathering resumes after it.
// Reset is synchronous and active low; it clears all sums and drops m_tvalid.
module normalized_cross_correlation_core import ncc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] pixel_a, [15:8] pixel_b
    input  logic        s_tlast,   // last_pair
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] correlation, signed Q1.15
    output logic        m_tuser    // [0] degenerate
);

    ncc_cmd_t    cmd;
    ncc_status_t status;

    // The controller sequences accumulation, the product chain, the division
    // and the square root.
    ncc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the sums, the shared arithmetic units and the
    // result register.
    ncc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .pixel_a     (s_tdata[7:0]),
        .pixel_b     (s_tdata[15:8]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .correlation (m_tdata),
        .degenerate  (m_tuser)
    );

endmodule

// ===== sv/ncc_checker.sv =====
module ncc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("degenerate result with nonzero correlation");

    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("correlation not saturated");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken while the window is being finished");

endmodule

bind normalized_cross_correlation_core ncc_checker u_ncc_checker (.*);
